FILE: design/chgs_pkg.sv
// shared types and constants for the convex hull core
package chgs_pkg;

  localparam int unsigned MinHull = 3;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_PIV_RD,
    ST_PIV_CMP,
    ST_ORD0,
    ST_ORD,
    ST_SI_RD,
    ST_SI_V,
    ST_SI_VP,
    ST_SJ_CHK,
    ST_SJ_B,
    ST_SJ_BP,
    ST_SJ_W,
    ST_SC_RD,
    ST_SC_C,
    ST_SC_CP,
    ST_SC_CHK,
    ST_SC_W,
    ST_SC_P1,
    ST_SC_P2,
    ST_EM_RD,
    ST_EM_S,
    ST_EM_P,
    ST_EM_OUT
  } state_e;

  typedef struct packed {
    logic done;
    logic left;
    logic ahead;
  } geom_res_t;

endpackage

FILE: design/chgs_ram.sv
// single write port, single read port synchronous memory
module chgs_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/chgs_geom.sv
// pipelined cross product and distance compare unit
module chgs_geom import chgs_pkg::*; #(
  parameter int CW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [2*CW-1:0] o_i,
  input  logic [2*CW-1:0] a_i,
  input  logic [2*CW-1:0] b_i,
  output geom_res_t     res_o
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] ux_q, uy_q, vx_q, vy_q;
  logic signed [PW-1:0] l_q, r_q, ax_q, ay_q, bx_q, by_q;
  logic [PW:0]          da_q, db_q;
  logic                 gt_q, eq_q;
  logic                 v1_q, v2_q, v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ux_q <= $signed({a_i[CW-1], a_i[CW-1:0]}) - $signed({o_i[CW-1], o_i[CW-1:0]});
    uy_q <= $signed({a_i[2*CW-1], a_i[2*CW-1:CW]}) - $signed({o_i[2*CW-1], o_i[2*CW-1:CW]});
    vx_q <= $signed({b_i[CW-1], b_i[CW-1:0]}) - $signed({o_i[CW-1], o_i[CW-1:0]});
    vy_q <= $signed({b_i[2*CW-1], b_i[2*CW-1:CW]}) - $signed({o_i[2*CW-1], o_i[2*CW-1:CW]});
    l_q  <= PW'(ux_q) * PW'(vy_q);
    r_q  <= PW'(uy_q) * PW'(vx_q);
    ax_q <= PW'(ux_q) * PW'(ux_q);
    ay_q <= PW'(uy_q) * PW'(uy_q);
    bx_q <= PW'(vx_q) * PW'(vx_q);
    by_q <= PW'(vy_q) * PW'(vy_q);
    da_q <= {1'b0, ax_q} + {1'b0, ay_q};
    db_q <= {1'b0, bx_q} + {1'b0, by_q};
    gt_q <= l_q > r_q;
    eq_q <= l_q == r_q;
  end

  always_comb begin
    res_o.done = v3_q;
    res_o.left = gt_q;
    if (db_q == '0) begin
      res_o.ahead = 1'b0;
    end else if (da_q == '0) begin
      res_o.ahead = 1'b1;
    end else if (!eq_q) begin
      res_o.ahead = gt_q;
    end else begin
      res_o.ahead = da_q < db_q;
    end
  end

endmodule

FILE: design/convex_hull_graham_scan_core.sv
// convex hull of a point cloud by graham scan, top level
//
// channel  dir  tdata (low bit up)        tlast        tuser
// s_axis   in   point_x, point_y          point_last   -
// m_axis   out  hull_x, hull_y            hull_last    overflow
//
// points load at one word per cycle into the point memory
// after the last point the hull finds the pivot and writes the initial order,
// then insertion-sorts the points by angle, scans them with a turn test per point
// and a pop on each turn that is not to the left, and emits each hull vertex
// (every loaded point, with no stack read, for clouds under three points), waiting on output stalls
// the geometry unit is pipelined and the memory reads are registered
// reset clears counters and control, memories need no clearing
// input is not taken while the hull is computed or emitted
module convex_hull_graham_scan_core import chgs_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i, // point_x, point_y
  input  logic s_axis_tlast_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata_o, // hull_x, hull_y
  output logic m_axis_tlast_o,
  output logic m_axis_tuser_o                               // overflow
);

  localparam int CW   = COORD_BITS;
  localparam int PTW  = 2 * CW;
  localparam int DBW  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);

  state_e state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, k_q, k_d, dep_q, dep_d;
  logic ovf_q, ovf_d, small_q, small_d;
  logic [IW-1:0] piv_idx_q, piv_idx_d, v_idx_q, v_idx_d, b_idx_q, b_idx_d, c_idx_q, c_idx_d;
  logic [PTW-1:0] piv_pt_q, piv_pt_d, v_pt_q, v_pt_d, c_pt_q, c_pt_d;
  logic [PTW-1:0] s1_q, s1_d, s2_q, s2_d, odata_q, odata_d;
  logic ovalid_q, ovalid_d, olast_q, olast_d, oovf_q, oovf_d;

  logic p_we, o_we, s_we;
  logic [IW-1:0] p_waddr, p_raddr, o_waddr, o_raddr, s_waddr, s_raddr;
  logic [IW-1:0] o_wdata, s_wdata, o_rdata, s_rdata;
  logic [PTW-1:0] p_wdata, p_rdata;
  logic g_start;
  logic [PTW-1:0] g_o, g_a, g_b;
  geom_res_t g_res;

  logic in_acc, out_acc, do_push, sort_next;
  logic [CNTW-1:0] cnt_m1, i_p1, j_m1, dep_m3, total;
  logic signed [CW-1:0] rd_x, rd_y, pv_x, pv_y;
  logic lower;

  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o & m_axis_tready_i;
  assign cnt_m1  = cnt_q - 1'b1;
  assign i_p1    = i_q + 1'b1;
  assign j_m1    = j_q - 1'b1;
  assign dep_m3  = dep_q - CNTW'(3);
  assign total   = small_q ? cnt_q : dep_q;
  assign rd_x    = $signed(p_rdata[CW-1:0]);
  assign rd_y    = $signed(p_rdata[PTW-1:CW]);
  assign pv_x    = $signed(piv_pt_q[CW-1:0]);
  assign pv_y    = $signed(piv_pt_q[PTW-1:CW]);
  assign lower   = (rd_y < pv_y) || ((rd_y == pv_y) && (rd_x < pv_x));

  chgs_ram #(.W(PTW), .D(MAX_POINTS)) u_pts (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  chgs_ram #(.W(IW), .D(MAX_POINTS)) u_ord (
    .clk_i, .we_i(o_we), .waddr_i(o_waddr), .wdata_i(o_wdata),
    .raddr_i(o_raddr), .rdata_o(o_rdata)
  );

  chgs_ram #(.W(IW), .D(MAX_POINTS)) u_stk (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  chgs_geom #(.CW(CW)) u_geom (
    .clk_i, .rst_ni, .start_i(g_start), .o_i(g_o), .a_i(g_a), .b_i(g_b), .res_o(g_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      dep_q    <= '0;
      ovf_q    <= 1'b0;
      small_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      dep_q    <= dep_d;
      ovf_q    <= ovf_d;
      small_q  <= small_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    piv_idx_q <= piv_idx_d;
    piv_pt_q  <= piv_pt_d;
    v_idx_q   <= v_idx_d;
    v_pt_q    <= v_pt_d;
    b_idx_q   <= b_idx_d;
    c_idx_q   <= c_idx_d;
    c_pt_q    <= c_pt_d;
    s1_q      <= s1_d;
    s2_q      <= s2_d;
    odata_q   <= odata_d;
    olast_q   <= olast_d;
    oovf_q    <= oovf_d;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    dep_d     = dep_q;
    ovf_d     = ovf_q;
    small_d   = small_q;
    ovalid_d  = ovalid_q;
    piv_idx_d = piv_idx_q;
    piv_pt_d  = piv_pt_q;
    v_idx_d   = v_idx_q;
    v_pt_d    = v_pt_q;
    b_idx_d   = b_idx_q;
    c_idx_d   = c_idx_q;
    c_pt_d    = c_pt_q;
    s1_d      = s1_q;
    s2_d      = s2_q;
    odata_d   = odata_q;
    olast_d   = olast_q;
    oovf_d    = oovf_q;
    p_we      = 1'b0;
    p_waddr   = cnt_q[IW-1:0];
    p_wdata   = s_axis_tdata_i[PTW-1:0];
    p_raddr   = '0;
    o_we      = 1'b0;
    o_waddr   = '0;
    o_wdata   = '0;
    o_raddr   = '0;
    s_we      = 1'b0;
    s_waddr   = '0;
    s_wdata   = '0;
    s_raddr   = '0;
    g_start   = 1'b0;
    g_o       = s2_q;
    g_a       = s1_q;
    g_b       = c_pt_q;
    s_axis_tready_o = 1'b0;
    do_push   = 1'b0;
    sort_next = 1'b0;

    case (state_q)
      ST_LOAD: begin
        s_axis_tready_o = 1'b1;
        if (in_acc) begin
          if (cnt_q < CNTW'(MAX_POINTS)) begin
            p_we  = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            i_d = '0;
            if (cnt_d < CNTW'(MinHull)) begin
              small_d = 1'b1;
              state_d = ST_EM_RD;
            end else begin
              small_d = 1'b0;
              state_d = ST_PIV_RD;
            end
          end
        end
      end
      ST_PIV_RD: begin
        p_raddr = i_q[IW-1:0];
        state_d = ST_PIV_CMP;
      end
      ST_PIV_CMP: begin
        if (i_q == '0 || lower) begin
          piv_pt_d  = p_rdata;
          piv_idx_d = i_q[IW-1:0];
        end
        if (i_q == cnt_m1) begin
          state_d = ST_ORD0;
        end else begin
          i_d     = i_p1;
          state_d = ST_PIV_RD;
        end
      end
      ST_ORD0: begin
        o_we    = 1'b1;
        o_waddr = '0;
        o_wdata = piv_idx_q;
        k_d     = CNTW'(1);
        i_d     = '0;
        state_d = ST_ORD;
      end
      ST_ORD: begin
        if (i_q[IW-1:0] != piv_idx_q) begin
          o_we    = 1'b1;
          o_waddr = k_q[IW-1:0];
          o_wdata = i_q[IW-1:0];
          k_d     = k_q + 1'b1;
        end
        if (i_q == cnt_m1) begin
          i_d     = CNTW'(2);
          state_d = ST_SI_RD;
        end else begin
          i_d = i_p1;
        end
      end
      ST_SI_RD: begin
        o_raddr = i_q[IW-1:0];
        state_d = ST_SI_V;
      end
      ST_SI_V: begin
        v_idx_d = o_rdata;
        p_raddr = o_rdata;
        state_d = ST_SI_VP;
      end
      ST_SI_VP: begin
        v_pt_d  = p_rdata;
        j_d     = i_q;
        state_d = ST_SJ_CHK;
      end
      ST_SJ_CHK: begin
        if (j_q > CNTW'(1)) begin
          o_raddr = j_m1[IW-1:0];
          state_d = ST_SJ_B;
        end else begin
          o_we      = 1'b1;
          o_waddr   = j_q[IW-1:0];
          o_wdata   = v_idx_q;
          sort_next = 1'b1;
        end
      end
      ST_SJ_B: begin
        b_idx_d = o_rdata;
        p_raddr = o_rdata;
        state_d = ST_SJ_BP;
      end
      ST_SJ_BP: begin
        g_start = 1'b1;
        g_o     = piv_pt_q;
        g_a     = v_pt_q;
        g_b     = p_rdata;
        state_d = ST_SJ_W;
      end
      ST_SJ_W: begin
        if (g_res.done) begin
          o_we    = 1'b1;
          o_waddr = j_q[IW-1:0];
          if (g_res.ahead) begin
            o_wdata = b_idx_q;
            j_d     = j_m1;
            state_d = ST_SJ_CHK;
          end else begin
            o_wdata   = v_idx_q;
            sort_next = 1'b1;
          end
        end
      end
      ST_SC_RD: begin
        o_raddr = i_q[IW-1:0];
        state_d = ST_SC_C;
      end
      ST_SC_C: begin
        c_idx_d = o_rdata;
        p_raddr = o_rdata;
        state_d = ST_SC_CP;
      end
      ST_SC_CP: begin
        c_pt_d  = p_rdata;
        state_d = ST_SC_CHK;
      end
      ST_SC_CHK: begin
        if (dep_q >= CNTW'(2)) begin
          g_start = 1'b1;
          state_d = ST_SC_W;
        end else begin
          do_push = 1'b1;
        end
      end
      ST_SC_W: begin
        if (g_res.done) begin
          if (!g_res.left) begin
            dep_d = dep_q - 1'b1;
            s1_d  = s2_q;
            if (dep_q >= CNTW'(3)) begin
              s_raddr = dep_m3[IW-1:0];
              state_d = ST_SC_P1;
            end else begin
              state_d = ST_SC_CHK;
            end
          end else begin
            do_push = 1'b1;
          end
        end
      end
      ST_SC_P1: begin
        p_raddr = s_rdata;
        state_d = ST_SC_P2;
      end
      ST_SC_P2: begin
        s2_d    = p_rdata;
        state_d = ST_SC_CHK;
      end
      ST_EM_RD: begin
        if (small_q) begin
          p_raddr = i_q[IW-1:0];
          state_d = ST_EM_P;
        end else begin
          s_raddr = i_q[IW-1:0];
          state_d = ST_EM_S;
        end
      end
      ST_EM_S: begin
        p_raddr = s_rdata;
        state_d = ST_EM_P;
      end
      ST_EM_P: begin
        ovalid_d = 1'b1;
        odata_d  = p_rdata;
        olast_d  = (i_p1 == total);
        oovf_d   = ovf_q;
        state_d  = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        if (out_acc) begin
          ovalid_d = 1'b0;
          if (olast_q) begin
            cnt_d   = '0;
            dep_d   = '0;
            ovf_d   = 1'b0;
            i_d     = '0;
            state_d = ST_LOAD;
          end else begin
            i_d     = i_p1;
            state_d = ST_EM_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    if (sort_next) begin
      if (i_q == cnt_m1) begin
        i_d     = '0;
        dep_d   = '0;
        state_d = ST_SC_RD;
      end else begin
        i_d     = i_p1;
        state_d = ST_SI_RD;
      end
    end

    if (do_push) begin
      s_we    = 1'b1;
      s_waddr = dep_q[IW-1:0];
      s_wdata = c_idx_q;
      s2_d    = s1_q;
      s1_d    = c_pt_q;
      dep_d   = dep_q + 1'b1;
      if (i_q == cnt_m1) begin
        i_d     = '0;
        state_d = ST_EM_RD;
      end else begin
        i_d     = i_p1;
        state_d = ST_SC_RD;
      end
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = DBW'(odata_q);
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tuser_o  = oovf_q;

  a_out_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> state_q == ST_EM_OUT)
    else $error("output word outside emit");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("input taken while output pending");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dep_q <= cnt_q || state_q == ST_LOAD)
    else $error("stack deeper than point count");

  a_geom_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_res.done |-> (state_q == ST_SJ_W || state_q == ST_SC_W))
    else $error("geometry result outside wait state");

endmodule

FILE: tb/convex_hull_graham_scan_core_test.sv
// self-checking testbench for the convex hull core: directed and random point clouds against a hull predictor
class hull_scoreboard;
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
    logic        ovf;
  } vertex_t;

  logic signed [15:0] cloud_x[64];
  logic signed [15:0] cloud_y[64];
  int unsigned cloud_n;
  bit cloud_ovf;
  vertex_t hull_q[$];
  int unsigned mismatches;

  function new();
    cloud_n = 0;
    cloud_ovf = 0;
    mismatches = 0;
  endfunction

  function int turn_sign(int a, int b, int c);
    longint ux, uy, vx, vy, l, r;
    ux = longint'(cloud_x[b]) - cloud_x[a];
    uy = longint'(cloud_y[b]) - cloud_y[a];
    vx = longint'(cloud_x[c]) - cloud_x[a];
    vy = longint'(cloud_y[c]) - cloud_y[a];
    l = ux * vy;
    r = uy * vx;
    return (l > r) ? 1 : ((l < r) ? -1 : 0);
  endfunction

  function longint dist_sq(int a, int b);
    longint dx, dy;
    dx = longint'(cloud_x[b]) - cloud_x[a];
    dy = longint'(cloud_y[b]) - cloud_y[a];
    return dx * dx + dy * dy;
  endfunction

  function bit angle_precedes(int p, int a, int b);
    longint da, db;
    int t;
    da = dist_sq(p, a);
    db = dist_sq(p, b);
    if (db == 0) return 0;
    if (da == 0) return 1;
    t = turn_sign(p, a, b);
    if (t != 0) return t > 0;
    return da < db;
  endfunction

  function void push_vertex(int idx, bit last);
    vertex_t v;
    v.x = cloud_x[idx];
    v.y = cloud_y[idx];
    v.last = last;
    v.ovf = cloud_ovf;
    hull_q.insert(hull_q.size(), v);
  endfunction

  function void note_point(logic [15:0] x, logic [15:0] y, bit last);
    int order[64];
    int stk[64];
    int piv, k, j, v, sd;
    if (cloud_n < 64) begin
      cloud_x[cloud_n] = x;
      cloud_y[cloud_n] = y;
      cloud_n++;
    end else begin
      cloud_ovf = 1;
    end
    if (!last) return;
    if (cloud_n < 3) begin
      for (int i = 0; i < cloud_n; i++) push_vertex(i, i + 1 == cloud_n);
    end else begin
      piv = 0;
      for (int i = 1; i < cloud_n; i++)
        if (cloud_y[i] < cloud_y[piv] || (cloud_y[i] == cloud_y[piv] && cloud_x[i] < cloud_x[piv]))
          piv = i;
      order[0] = piv;
      k = 1;
      for (int i = 0; i < cloud_n; i++) if (i != piv) order[k++] = i;
      for (int i = 2; i < cloud_n; i++) begin
        v = order[i];
        j = i;
        while (j > 1 && angle_precedes(piv, v, order[j-1])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = v;
      end
      sd = 0;
      for (int i = 0; i < cloud_n; i++) begin
        while (sd >= 2 && turn_sign(stk[sd-2], stk[sd-1], order[i]) <= 0) sd--;
        stk[sd++] = order[i];
      end
      for (int i = 0; i < sd; i++) push_vertex(stk[i], i + 1 == sd);
    end
    cloud_n = 0;
    cloud_ovf = 0;
  endfunction

  function void check_vertex(logic [15:0] x, logic [15:0] y, logic last, logic ovf);
    vertex_t e;
    if (hull_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected word x=%h y=%h last=%b ovf=%b", x, y, last, ovf);
      return;
    end
    e = hull_q.pop_front();
    if (e.x !== x || e.y !== y || e.last !== last || e.ovf !== ovf) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch exp x=%h y=%h last=%b ovf=%b got x=%h y=%h last=%b ovf=%b",
                 e.x, e.y, e.last, e.ovf, x, y, last, ovf);
    end
  endfunction
endclass

module convex_hull_graham_scan_core_test;
  import chgs_pkg::*;

  logic clk_i, rst_ni;
  logic s_axis_tvalid_i, s_axis_tready_o, s_axis_tlast_i;
  logic [31:0] s_axis_tdata_i;
  logic m_axis_tvalid_o, m_axis_tready_i, m_axis_tlast_o, m_axis_tuser_o;
  logic [31:0] m_axis_tdata_o;

  hull_scoreboard sb;
  int unsigned send_idle_pct, recv_idle_pct;
  bit hold_recv;
  longint unsigned cycle_count;

  convex_hull_graham_scan_core dut (.*);

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 3000000) begin
      $display("convex_hull_graham_scan_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_vertex(m_axis_tdata_o[15:0], m_axis_tdata_o[31:16], m_axis_tlast_o,
                      m_axis_tuser_o);

  always @(negedge clk_i)
    m_axis_tready_i <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);

  task automatic send_point(logic [15:0] x, logic [15:0] y, bit last);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tvalid_i = 1;
    s_axis_tdata_i = {y, x};
    s_axis_tlast_i = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_point(x, y, last);
    @(negedge clk_i);
    s_axis_tvalid_i = 0;
  endtask

  task automatic wait_drained();
    while (sb.hull_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(20)) - 10);
      default: return $urandom_range(3) == 0 ? 16'h8000 : 16'h7fff;
    endcase
  endfunction

  task automatic send_cloud(int n, int mode);
    for (int i = 0; i < n; i++) send_point(rand_coord(mode), rand_coord(mode), i == n - 1);
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    hold_recv = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    s_axis_tvalid_i = 0;
    s_axis_tdata_i = 0;
    s_axis_tlast_i = 0;
    m_axis_tready_i = 0;
    rst_ni = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    // directed: single, pair, extremes, collinear, duplicates
    send_point(16'h8000, 16'h7fff, 1);
    send_point(16'h7fff, 16'h8000, 0);
    send_point(16'h8000, 16'h8000, 1);
    send_point(16'h8000, 16'h8000, 0);
    send_point(16'h7fff, 16'h8000, 0);
    send_point(16'h7fff, 16'h7fff, 0);
    send_point(16'h8000, 16'h7fff, 1);
    for (int i = 0; i < 4; i++) send_point(16'(i), 16'(i), i == 3);
    for (int i = 0; i < 3; i++) send_point(16'h5, 16'h5, i == 2);
    send_point(16'd0, 16'd0, 0);
    send_point(16'd4, 16'd0, 0);
    send_point(16'd2, 16'd0, 0);
    send_point(16'd4, 16'd4, 0);
    send_point(16'd0, 16'd4, 0);
    send_point(16'd2, 16'd2, 1);
    wait_drained();
    // overflow: 66 points, dropped last still ends cloud
    send_cloud(66, 0);
    wait_drained();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 15 : (phase == 1 ? 65 : 0);
      recv_idle_pct = phase == 0 ? 65 : (phase == 1 ? 15 : 0);
      if (phase == 2) begin
        fork
          begin
            hold_recv = 1;
            repeat (400) @(negedge clk_i);
            hold_recv = 0;
          end
          begin
            send_cloud(10, 0);
            send_cloud(5, 0);
          end
        join
        wait_drained();
      end
      for (int c = 0; c < 12; c++) begin
        int n;
        n = $urandom_range(3) == 0 ? $urandom_range(2, 1) : $urandom_range(3, 16);
        send_cloud(n, $urandom_range(2));
        if (c == 5) wait_drained();
      end
    end
    wait_drained();
    repeat (2000) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.hull_q.size() == 0)
      $display("convex_hull_graham_scan_core regression: pass");
    else
      $display("convex_hull_graham_scan_core regression: fail");
    $finish;
  end
endmodule

FILE: convex_hull_graham_scan_core.f
design/chgs_pkg.sv
design/chgs_ram.sv
design/chgs_geom.sv
design/convex_hull_graham_scan_core.sv
tb/convex_hull_graham_scan_core_test.sv
